// ===== rtl/mbrg_pkg.sv =====
// Package for the multiply-with-carry bounded random generator.
// Holds operation codes, generator constants, the mask helper and the
// command/status structs shared by the controller and the datapath.
package mbrg_pkg;

    // Operation codes carried by a request
    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_SEED_BYTE = 3'd1,
        OP_COMMIT    = 3'd2,
        OP_LOAD      = 3'd3,
        OP_READ      = 3'd4,
        OP_RAW       = 3'd5,
        OP_BOUNDED   = 3'd6,
        OP_NONE      = 3'd7
    } op_t;

    localparam logic [31:0] MWC_MULT    = 32'd2131995753;
    localparam logic [31:0] WORD_ONES   = 32'hffff_ffff;
    localparam logic [31:0] FIXED_CARRY = MWC_MULT - 32'd1;
    localparam int          TRIES_W     = 16;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic execute;     // request taken: run simple ops, capture draw operands
        logic step;        // advance the generator by one step
        logic capture_hi;  // hold the masked high word of a wide draw
        logic reject;      // count a rejected attempt
        logic set_ok;      // hold the accepted candidate as the result
        logic set_fail;    // hold a failed bounded draw as the result
        logic load_out;    // move the result into the output register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic lim_zero;    // captured limit is zero
        logic lim_wide;    // captured limit needs more than 32 bits
        logic below;       // candidate lies below the limit
        logic give_up;     // generator stuck or attempts exhausted
        logic out_free;    // output register can take a result
    } stat_t;

    // All ones up to the highest set bit
    function automatic logic [31:0] bit_length_mask(input logic [31:0] m);
        logic [31:0] r;
        r = m;
        r = r | (r >> 1);
        r = r | (r >> 2);
        r = r | (r >> 4);
        r = r | (r >> 8);
        r = r | (r >> 16);
        return r;
    endfunction

endpackage

// ===== rtl/mbrg_datapath.sv =====
// Datapath of the bounded random generator: generator and seed registers,
// step multiplier, draw candidate compare and the output register.
// Depends on mbrg_pkg.
module mbrg_datapath
    import mbrg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [2:0]  operation,
    input  logic [7:0]  seed_byte,
    input  logic [63:0] limit,
    input  logic [31:0] load_word,
    input  logic [31:0] load_carry,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [63:0] value,
    output logic        status,
    output logic [31:0] word_out,
    output logic [31:0] carry_out
);

    logic [31:0]        gen_word_reg,   gen_word_next;
    logic [31:0]        gen_carry_reg,  gen_carry_next;
    logic [31:0]        seed_word_reg,  seed_word_next;
    logic [31:0]        seed_carry_reg, seed_carry_next;
    logic [2:0]         seed_pos_reg,   seed_pos_next;
    logic [63:0]        lim_reg;
    logic [31:0]        mask_reg;
    logic [31:0]        hi_reg;
    logic [TRIES_W-1:0] tries_reg;
    logic [63:0]        res_value_reg;
    logic               res_status_reg;
    logic               out_valid_reg;
    logic [63:0]        out_value_reg;
    logic               out_status_reg;
    logic [31:0]        out_word_reg;
    logic [31:0]        out_carry_reg;

    logic [63:0]        step_x;
    logic [31:0]        seed_ext;
    logic [31:0]        seed_add;
    logic [63:0]        cand;
    logic               at_fixed;
    logic               commit_bump;
    op_t                op;

    assign op = op_t'(operation);

    // One generator step: 32x32 product plus carry
    assign step_x = (64'(MWC_MULT) * 64'(gen_word_reg)) + 64'(gen_carry_reg);

    // Sign-extended seed byte moved into its byte lane
    assign seed_ext = {{24{seed_byte[7]}}, seed_byte};
    assign seed_add = seed_ext << {seed_pos_reg[1:0], 3'b000};

    assign commit_bump = ((seed_word_reg == 32'd0) && (seed_carry_reg == 32'd0))
                      || ((seed_word_reg == WORD_ONES) && (seed_carry_reg == FIXED_CARRY));

    assign at_fixed = (gen_word_reg == WORD_ONES) && (gen_carry_reg == FIXED_CARRY);

    // Candidate for the bounded draw
    assign cand = stat.lim_wide ? {hi_reg, gen_word_reg}
                                : {32'd0, gen_word_reg & mask_reg};

    assign stat.lim_zero = (lim_reg == 64'd0);
    assign stat.lim_wide = (lim_reg[63:32] != 32'd0);
    assign stat.below    = (cand < lim_reg);
    assign stat.give_up  = at_fixed || (tries_reg == {TRIES_W{1'b1}});
    assign stat.out_free = !out_valid_reg || !out_stall;

    // Next generator and seed state
    always_comb
    begin
        gen_word_next   = gen_word_reg;
        gen_carry_next  = gen_carry_reg;
        seed_word_next  = seed_word_reg;
        seed_carry_next = seed_carry_reg;
        seed_pos_next   = seed_pos_reg;
        if (cmd.execute)
        begin
            unique case (op)
                OP_CLEAR:
                begin
                    seed_word_next  = 32'd0;
                    seed_carry_next = 32'd0;
                    seed_pos_next   = 3'd0;
                end
                OP_SEED_BYTE:
                begin
                    if (!seed_pos_reg[2])
                        seed_word_next = seed_word_reg + seed_add;
                    else
                        seed_carry_next = seed_carry_reg + seed_add;
                    seed_pos_next = seed_pos_reg + 3'd1;
                end
                OP_COMMIT:
                begin
                    gen_word_next  = seed_word_reg;
                    gen_carry_next = seed_carry_reg + {31'd0, commit_bump};
                end
                OP_LOAD:
                begin
                    gen_word_next  = load_word;
                    gen_carry_next = load_carry;
                end
                OP_RAW:
                begin
                    gen_word_next  = step_x[31:0];
                    gen_carry_next = step_x[63:32];
                end
                OP_READ, OP_BOUNDED, OP_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.step)
        begin
            gen_word_next  = step_x[31:0];
            gen_carry_next = step_x[63:32];
        end
    end

    // Hold generator and seed state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_word_reg   <= 32'd0;
            gen_carry_reg  <= 32'd1;
            seed_word_reg  <= 32'd0;
            seed_carry_reg <= 32'd0;
            seed_pos_reg   <= 3'd0;
        end
        else
        begin
            gen_word_reg   <= gen_word_next;
            gen_carry_reg  <= gen_carry_next;
            seed_word_reg  <= seed_word_next;
            seed_carry_reg <= seed_carry_next;
            seed_pos_reg   <= seed_pos_next;
        end
    end

    // Capture draw operands, count attempts and hold the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tries_reg <= '0;
        end
        else if (cmd.execute)
        begin
            tries_reg <= '0;
        end
        else if (cmd.reject)
        begin
            tries_reg <= tries_reg + TRIES_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            lim_reg  <= limit;
            mask_reg <= bit_length_mask((limit[63:32] != 32'd0) ? limit[63:32]
                                                                : limit[31:0]);
            res_status_reg <= (op == OP_BOUNDED) && (limit == 64'd0);
            res_value_reg  <= (op == OP_RAW) ? {32'd0, step_x[31:0]} : 64'd0;
        end
        else if (cmd.set_ok)
        begin
            res_value_reg  <= cand;
            res_status_reg <= 1'b0;
        end
        else if (cmd.set_fail)
        begin
            res_value_reg  <= 64'd0;
            res_status_reg <= 1'b1;
        end
        if (cmd.capture_hi)
            hi_reg <= gen_word_reg & mask_reg;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
            out_word_reg   <= gen_word_reg;
            out_carry_reg  <= gen_carry_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = out_value_reg;
    assign status    = out_status_reg;
    assign word_out  = out_word_reg;
    assign carry_out = out_carry_reg;

endmodule

// ===== rtl/mbrg_ctrl.sv =====
// Controller of the bounded random generator: sequences generator steps,
// candidate checks and the hand-over of each result.
// Depends on mbrg_pkg.
module mbrg_ctrl
    import mbrg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] operation,
    input  stat_t      stat,
    output cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_STEP,
        S_STEP_LO,
        S_TEST,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   accept;
    op_t    op;

    assign op       = op_t'(operation);
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    // Decode commands and the next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.execute = 1'b1;
                    if (op == OP_NONE)
                        state_next = S_IDLE;
                    else if (op == OP_BOUNDED)
                        state_next = S_CHECK;
                    else
                        state_next = S_DONE;
                end
            end
            S_CHECK:
            begin
                // a zero limit goes straight to the hand-over as a failed draw
                if (stat.lim_zero)
                    state_next = S_DONE;
                else
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = stat.lim_wide ? S_STEP_LO : S_TEST;
            end
            S_STEP_LO:
            begin
                cmd.step       = 1'b1;
                cmd.capture_hi = 1'b1;
                state_next     = S_TEST;
            end
            S_TEST:
            begin
                // keep the candidate, give up on a stuck generator or exhausted attempts, or retry
                if (stat.below)
                begin
                    cmd.set_ok = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.give_up)
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.reject = 1'b1;
                    state_next = S_STEP;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/mwc_bounded_random_generator_core.sv =====
// Top level of the multiply-with-carry bounded random generator.
// Joins the controller and the datapath. Depends on mbrg_pkg.
//
// Takes one request at a time on the input channel and gives one result per
// request (operation 7 gives none). Clear, seed byte, commit, load, read and
// raw draw pass through the accepting state and then load the output register
// once it is free. A bounded draw passes through the accepting state, a limit
// check and, at the end, the load of the result; in between, each attempt
// takes a generator step in the single 32x32 multiply-add unit plus the
// candidate check, and a limit wider than 32 bits takes a second step, the
// first giving the high word. A zero limit goes from the check straight to
// the load; rejections add attempts. The output register holds each result
// until it is taken, and the next request is accepted once that register
// has been loaded.
module mwc_bounded_random_generator_core
    import mbrg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [7:0]  seed_byte,
    input  logic [63:0] limit,
    input  logic [31:0] load_word,
    input  logic [31:0] load_carry,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] value,
    output logic        status,
    output logic [31:0] word_out,
    output logic [31:0] carry_out
);

    cmd_t  cmd;
    stat_t stat;

    mbrg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .stat      (stat),
        .cmd       (cmd)
    );

    mbrg_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .operation  (operation),
        .seed_byte  (seed_byte),
        .limit      (limit),
        .load_word  (load_word),
        .load_carry (load_carry),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .value      (value),
        .status     (status),
        .word_out   (word_out),
        .carry_out  (carry_out)
    );

endmodule
